// ===== rtl/core/wndd_pkg.sv =====
// Shared types, constants and sizing for the window near-duplicate detector.
package wndd_pkg;

  // Deepest window the cell chain holds.
  localparam int WINDOW_MAX = 64;

  // Bits of a fill count that can reach WINDOW_MAX itself.
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  // Fixed field widths.
  localparam int VALUE_W   = 32;
  localparam int WLEN_W    = 7;
  localparam int MDIFF_W   = 31;
  localparam int CFG_DATA_W = 31;

  // Width used when comparing a window length with the chain depth.
  localparam int LEN_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

  // First reduction stage: hit bits are combined in groups of this size.
  localparam int GROUP_W  = 8;
  localparam int N_GROUPS = (WINDOW_MAX + GROUP_W - 1) / GROUP_W;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_WINDOW_LEN = 1'b0,
    CFG_MAX_DIFF   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      start_req;
  } in_beat_t;

  typedef struct packed {
    logic hit;
    logic seen_hit;
  } out_beat_t;

  // Control shared by every cell of the chain.
  typedef struct packed {
    logic accept;   // an input beat is taken: the window shifts
    logic advance;  // the pipeline moves on: the hit bit is captured
  } cell_ctrl_t;

endpackage

// ===== rtl/core/window_near_duplicate_detector.sv =====
// Top level of the window near-duplicate detector: cell chain, reduction and sticky flag.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      valid / stall      value, start_req (in_beat_t)
//   out_     output     valid / stall      hit, seen_hit (out_beat_t)
//   cfg_     input      valid / ready      index, data (window_len, max_diff)
//
// A beat may enter in every cycle while in_stall is low; its result passes
// through three registers before it is offered: the compare stage
// in the cells, which captures at the taking edge itself, the group OR
// stage and the output register that also folds in the sticky flag.
// The whole pipeline moves as one: while a result waits under out_stall,
// in_stall is raised and nothing shifts. Reset clears the fill count, the
// sticky flag and the pipeline valid bits and sets window_len to 1 and
// max_diff to 0; window entries are not cleared, since only entries
// written in the current sequence are ever compared.
module window_near_duplicate_detector
  import wndd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,

  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [WLEN_W-1:0]  window_len_r;
  logic [MDIFF_W-1:0] max_diff_r;

  // Sequence state.
  logic [CNT_W-1:0] filled_r;
  logic [CNT_W-1:0] filled_nxt;
  logic [CNT_W-1:0] filled_eff;
  logic             sticky_r;
  logic             sticky_nxt;

  // Pipeline control.
  logic       advance;
  logic       accept;
  logic       v1_r;
  logic       v2_r;
  logic       start1_r;
  logic       start2_r;
  logic       out_valid_r;
  out_beat_t  out_data_r;
  cell_ctrl_t cell_ctrl;

  // Number of entries compared for the beat being taken.
  logic [LEN_W-1:0] len_clamped;
  logic [LEN_W-1:0] cmp_count;

  logic [WINDOW_MAX-1:0]           cell_active;
  logic [WINDOW_MAX-1:0]           cell_hit;
  logic signed [VALUE_W-1:0]       chain [WINDOW_MAX+1];
  logic [N_GROUPS-1:0]             group_hit;
  logic                            item_hit;

  // The register port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WLEN_W'(1);
      max_diff_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW_LEN: window_len_r <= cfg_data[WLEN_W-1:0];
        CFG_MAX_DIFF:   max_diff_r   <= cfg_data[MDIFF_W-1:0];
        default:        ;
      endcase
    end
  end

  // The pipeline holds only while a finished result is refused downstream.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  assign cell_ctrl.accept  = accept;
  assign cell_ctrl.advance = advance;

  // A start request empties the window before the value is checked. Only
  // the newest min(filled, window_len) entries take part, with the length
  // clamped to the chain depth.
  always_comb begin
    filled_eff = in_data.start_req ? '0 : filled_r;
    if (LEN_W'(window_len_r) > LEN_W'(WINDOW_MAX)) begin
      len_clamped = LEN_W'(WINDOW_MAX);
    end else begin
      len_clamped = LEN_W'(window_len_r);
    end
    if (len_clamped > LEN_W'(filled_eff)) begin
      cmp_count = LEN_W'(filled_eff);
    end else begin
      cmp_count = len_clamped;
    end
    if (filled_eff < CNT_W'(WINDOW_MAX)) begin
      filled_nxt = filled_eff + CNT_W'(1);
    end else begin
      filled_nxt = filled_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
    end else if (accept) begin
      filled_r <= filled_nxt;
    end
  end

  // The chain: the new value enters cell 0 and each entry moves one cell on.
  assign chain[0] = in_data.value;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    assign cell_active[i] = cmp_count > LEN_W'(i);

    wndd_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .active    (cell_active[i] && accept),
      .value     (in_data.value),
      .max_diff  (max_diff_r),
      .entry_in  (chain[i]),
      .entry_out (chain[i+1]),
      .hit_out   (cell_hit[i])
    );
  end

  wndd_or_tree u_or_tree (
    .clk     (clk),
    .advance (advance),
    .hits    (cell_hit),
    .groups  (group_hit)
  );

  // Valid bits and the start flag travel alongside the hit bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (advance) begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      start1_r <= in_data.start_req;
      start2_r <= start1_r;
    end
  end

  // Final OR and the sticky flag, which is updated strictly in beat order.
  assign item_hit   = |group_hit;
  assign sticky_nxt = (start2_r ? 1'b0 : sticky_r) | item_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sticky_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= v2_r;
      if (v2_r) begin
        sticky_r <= sticky_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v2_r) begin
      out_data_r.hit      <= item_hit;
      out_data_r.seen_hit <= sticky_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/wndd_cell.sv =====
// One window cell: holds an entry, hands it on, and compares it with the new value.
module wndd_cell
  import wndd_pkg::*;
(
  input  logic                      clk,
  input  cell_ctrl_t                ctrl,
  input  logic                      active,
  input  logic signed [VALUE_W-1:0] value,
  input  logic        [MDIFF_W-1:0] max_diff,
  input  logic signed [VALUE_W-1:0] entry_in,
  output logic signed [VALUE_W-1:0] entry_out,
  output logic                      hit_out
);

  logic signed [VALUE_W-1:0] entry_r;
  logic                      hit_r;
  logic                      hit_nxt;
  logic signed [VALUE_W:0]   diff;
  logic        [VALUE_W:0]   mag;

  // The difference is formed one bit wider so it cannot overflow.
  always_comb begin
    diff = $signed({value[VALUE_W-1], value}) - $signed({entry_r[VALUE_W-1], entry_r});
    mag  = diff[VALUE_W] ? (VALUE_W+1)'(-diff) : $unsigned(diff);
    hit_nxt = active && (mag <= {{(VALUE_W+1-MDIFF_W){1'b0}}, max_diff});
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      entry_r <= entry_in;
    end
    if (ctrl.advance) begin
      hit_r <= hit_nxt;
    end
  end

  assign entry_out = entry_r;
  assign hit_out   = hit_r;

endmodule

// ===== rtl/core/wndd_or_tree.sv =====
// First registered level of the hit reduction: ORs the cell hit bits in groups.
module wndd_or_tree
  import wndd_pkg::*;
(
  input  logic                  clk,
  input  logic                  advance,
  input  logic [WINDOW_MAX-1:0] hits,
  output logic [N_GROUPS-1:0]   groups
);

  localparam int PAD_W = N_GROUPS * GROUP_W;

  logic [PAD_W-1:0]    hits_pad;
  logic [N_GROUPS-1:0] groups_r;
  logic [N_GROUPS-1:0] groups_nxt;

  always_comb begin
    hits_pad = '0;
    hits_pad[WINDOW_MAX-1:0] = hits;
    for (int g = 0; g < N_GROUPS; g++) begin
      groups_nxt[g] = |hits_pad[g*GROUP_W +: GROUP_W];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      groups_r <= groups_nxt;
    end
  end

  assign groups = groups_r;

endmodule
